// ===== src/seeded_hash_probability_gate_top_defines.svh =====
// Assertion macros shared by the seeded hash probability gate RTL.
// Included by the modules that carry concurrent checks; needs no other file.
`ifndef SEEDED_HASH_PROBABILITY_GATE_TOP_DEFINES_SVH
`define SEEDED_HASH_PROBABILITY_GATE_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked outside reset.
`define SHPG_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("shpg check failed");

// Next-cycle implication, checked outside reset.
`define SHPG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("shpg check failed");

// Next-cycle implication that also holds across reset.
`define SHPG_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("shpg check failed");

`else

`define SHPG_ASSERT_IMP(label, clk, rst, ante, cons)
`define SHPG_ASSERT_NEXT(label, clk, rst, ante, cons)
`define SHPG_ASSERT_NEXT_ALWAYS(label, clk, ante, cons)

`endif

`endif

// ===== src/shpg_pkg.sv =====
// Shared types, constants and the word selection function of the hash gate.
// Used by the mix cells, the gate stage and the top level.
package shpg_pkg;

   // Hash constants.
   localparam logic [31:0] HASH_START  = 32'h811c_9dc5;
   localparam logic [31:0] COMBINE_ADD = 32'h9e37_79b9;
   localparam logic [31:0] FINAL_MUL_A = 32'h7feb_352d;
   localparam logic [31:0] FINAL_MUL_B = 32'h846c_a68b;

   // Decision constants.
   localparam logic [6:0] PERCENT_FULL = 7'd100;
   localparam int FRACTION_BITS = 24;

   // One mix cell per absorbed word.
   localparam int NUM_CELLS = 7;

   // Configuration register map (byte address).
   localparam int CSR_ADDR_WIDTH = 2;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_SEED_ADDR = 2'd0;

   // Which word a mix cell absorbs, in absorb order.
   typedef enum logic [2:0] {
      WORD_SEED,
      WORD_CHANNEL,
      WORD_LINE,
      WORD_STEP,
      WORD_ROLE,
      WORD_EVENT,
      WORD_DRAW
   } word_sel_type;

   // Fields of one input item.
   typedef struct packed {
      logic [3:0]  channel;
      logic [15:0] line_number;
      logic [15:0] step_number;
      logic [7:0]  role_code;
      logic [15:0] event_number;
      logic [15:0] draw_number;
      logic        step_valid;
      logic        is_rest;
      logic [6:0]  play_percent;
   } item_type;

   // What travels down the chain with an item: running hash and the item.
   typedef struct packed {
      logic [31:0] hash;
      item_type    item;
   } lane_type;

   // Zero-extended word that a given cell absorbs.
   function automatic logic [31:0] mix_word(input word_sel_type sel, input item_type item,
                                            input logic [31:0] seed);
      logic [31:0] w;
      case (sel)
         WORD_SEED:    w = seed;
         WORD_CHANNEL: w = {28'd0, item.channel};
         WORD_LINE:    w = {16'd0, item.line_number};
         WORD_STEP:    w = {16'd0, item.step_number};
         WORD_ROLE:    w = {24'd0, item.role_code};
         WORD_EVENT:   w = {16'd0, item.event_number};
         WORD_DRAW:    w = {16'd0, item.draw_number};
         default:      w = 32'd0;
      endcase
      return w;
   endfunction

endpackage

// ===== src/shpg_req_if.sv =====
// Input channel interface of the hash gate: valid, ready and the item fields.
// Depends on nothing else.
interface shpg_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  channel;
   logic [15:0] line_number;
   logic [15:0] step_number;
   logic [7:0]  role_code;
   logic [15:0] event_number;
   logic [15:0] draw_number;
   logic        step_valid;
   logic        is_rest;
   logic [6:0]  play_percent;

   modport source (
      output valid, channel, line_number, step_number, role_code,
             event_number, draw_number, step_valid, is_rest, play_percent,
      input  ready
   );

   modport sink (
      input  valid, channel, line_number, step_number, role_code,
             event_number, draw_number, step_valid, is_rest, play_percent,
      output ready
   );
endinterface

// ===== src/shpg_rsp_if.sv =====
// Result channel interface of the hash gate: valid, ready and the result fields.
// Depends on nothing else.
interface shpg_rsp_if;
   logic        valid;
   logic        ready;
   logic [23:0] random_fraction;
   logic        plays;

   modport source (
      output valid, random_fraction, plays,
      input  ready
   );

   modport sink (
      input  valid, random_fraction, plays,
      output ready
   );
endinterface

// ===== src/shpg_mix_cell.sv =====
// One absorb round of the hash: combine, then the xorshift-multiply finalizer,
// in three registered stages with per-stage flow control. Uses shpg_pkg.
module shpg_mix_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  shpg_pkg::lane_type in_lane,
   input  logic [31:0]        in_word,
   output logic               out_valid,
   input  logic               out_ready,
   output shpg_pkg::lane_type out_lane
);

   logic               v1_ff, v2_ff, v3_ff;
   logic               v1_in, v2_in, v3_in;
   shpg_pkg::lane_type l1_ff, l2_ff, l3_ff;
   shpg_pkg::lane_type l1_in, l2_in, l3_in;
   logic               adv1, adv2, adv3;
   logic [31:0]        sum;
   logic [31:0]        comb;
   logic [31:0]        shr15;

   // A stage moves when it is empty or the stage after it moves.
   assign adv3     = !v3_ff || out_ready;
   assign adv2     = !v2_ff || adv3;
   assign adv1     = !v1_ff || adv2;
   assign in_ready = adv1;

   assign v1_in = adv1 ? in_valid : v1_ff;
   assign v2_in = adv2 ? v1_ff : v2_ff;
   assign v3_in = adv3 ? v2_ff : v3_ff;

   // Stage one: hash-combine with the word, then the first xorshift.
   always_comb begin
      sum  = in_word + shpg_pkg::COMBINE_ADD + {in_lane.hash[25:0], 6'd0}
             + {2'd0, in_lane.hash[31:2]};
      comb = in_lane.hash ^ sum;
      l1_in      = in_lane;
      l1_in.hash = comb ^ {16'd0, comb[31:16]};
   end

   // Stage two: first multiply.
   always_comb begin
      l2_in      = l1_ff;
      l2_in.hash = l1_ff.hash * shpg_pkg::FINAL_MUL_A;
   end

   // Stage three: second xorshift and multiply.
   always_comb begin
      shr15      = l2_ff.hash ^ {15'd0, l2_ff.hash[31:15]};
      l3_in      = l2_ff;
      l3_in.hash = shr15 * shpg_pkg::FINAL_MUL_B;
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // Payload registers load whenever their stage moves.
   always_ff @(posedge clock) begin
      if (adv1) begin
         l1_ff <= l1_in;
      end
      if (adv2) begin
         l2_ff <= l2_in;
      end
      if (adv3) begin
         l3_ff <= l3_in;
      end
   end

   // The closing xorshift is applied on the way out.
   always_comb begin
      out_lane      = l3_ff;
      out_lane.hash = l3_ff.hash ^ {16'd0, l3_ff.hash[31:16]};
   end
   assign out_valid = v3_ff;

endmodule

// ===== src/shpg_gate_stage.sv =====
// Play decision and result register at the end of the mix chain.
// Uses shpg_pkg and the assertion macros header.
`include "seeded_hash_probability_gate_top_defines.svh"

module shpg_gate_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  shpg_pkg::lane_type in_lane,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [23:0]        out_fraction,
   output logic               out_plays
);

   logic        valid_ff, valid_in;
   logic [23:0] fraction_ff, fraction_in;
   logic        plays_ff, plays_in;
   logic        in_fire;
   logic [30:0] lhs;
   logic [30:0] rhs;

   assign in_ready = !valid_ff || out_ready;
   assign in_fire  = in_valid && in_ready;

   // Exact compare: fraction * 100 < percent * 2^24.
   always_comb begin
      fraction_in = in_lane.hash[31:8];
      lhs = 31'(fraction_in) * 31'(shpg_pkg::PERCENT_FULL);
      rhs = 31'(in_lane.item.play_percent) << shpg_pkg::FRACTION_BITS;
      if (!in_lane.item.step_valid) begin
         plays_in = 1'b1;
      end else if (in_lane.item.is_rest) begin
         plays_in = 1'b0;
      end else if (in_lane.item.play_percent >= shpg_pkg::PERCENT_FULL) begin
         plays_in = 1'b1;
      end else if (in_lane.item.play_percent == 7'd0) begin
         plays_in = 1'b0;
      end else begin
         plays_in = lhs < rhs;
      end
   end

   // Result register: refills as soon as the waiting item is taken.
   assign valid_in = in_fire ? 1'b1 : (out_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire) begin
         fraction_ff <= fraction_in;
         plays_ff    <= plays_in;
      end
   end

   assign out_valid    = valid_ff;
   assign out_fraction = fraction_ff;
   assign out_plays    = plays_ff;

   // A draw with no active step always plays.
   `SHPG_ASSERT_NEXT(a_no_step_plays, clock, reset, in_fire && !in_lane.item.step_valid, plays_ff)
   // A rest on an active step never plays.
   `SHPG_ASSERT_NEXT(a_rest_silent, clock, reset, in_fire && in_lane.item.step_valid && in_lane.item.is_rest, !plays_ff)
   // The fraction shown is the top of the hash that came in.
   `SHPG_ASSERT_NEXT(a_fraction_kept, clock, reset, in_fire, fraction_ff == $past(in_lane.hash[31:8]))

endmodule

// ===== src/seeded_hash_probability_gate_top.sv =====
// Seeded hash probability gate: seven mix cells of three stages, then the gate.
// Each item passes the three registered stages of every mix cell, then the gate's result register.
// Throughput: one item per cycle; every stage holds its own item under back-pressure.
// Reset (synchronous): clears all stage valid bits and the seed register to zero.
// Uses shpg_pkg, both channel interfaces, shpg_mix_cell, shpg_gate_stage and the macros header.
`include "seeded_hash_probability_gate_top_defines.svh"

module seeded_hash_probability_gate_top (
   input  logic                                clock,
   input  logic                                reset,
   shpg_req_if.sink                            req_item,
   shpg_rsp_if.source                          rsp_item,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [shpg_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   logic [31:0]        seed_ff, seed_in;
   logic               csr_write;
   logic               lane_valid [shpg_pkg::NUM_CELLS+1];
   logic               lane_ready [shpg_pkg::NUM_CELLS+1];
   shpg_pkg::lane_type lane       [shpg_pkg::NUM_CELLS+1];

   // Configuration port: one seed register, zero wait states.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr == shpg_pkg::CSR_SEED_ADDR);
   assign seed_in    = csr_write ? csr_pwdata : seed_ff;
   assign csr_prdata = (csr_paddr == shpg_pkg::CSR_SEED_ADDR) ? seed_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= 32'd0;
      end else begin
         seed_ff <= seed_in;
      end
   end

   // Entry of the chain: the item with the starting hash.
   assign lane[0] = {shpg_pkg::HASH_START,
                     req_item.channel,
                     req_item.line_number,
                     req_item.step_number,
                     req_item.role_code,
                     req_item.event_number,
                     req_item.draw_number,
                     req_item.step_valid,
                     req_item.is_rest,
                     req_item.play_percent};
   assign lane_valid[0]  = req_item.valid;
   assign req_item.ready = lane_ready[0];

   // Chain of mix cells, each absorbing its own word.
   for (genvar k = 0; k < shpg_pkg::NUM_CELLS; k++) begin : g_cell
      logic [31:0] word;

      assign word = shpg_pkg::mix_word(shpg_pkg::word_sel_type'(3'(k)), lane[k].item, seed_ff);

      shpg_mix_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (lane_valid[k]),
         .in_ready  (lane_ready[k]),
         .in_lane   (lane[k]),
         .in_word   (word),
         .out_valid (lane_valid[k+1]),
         .out_ready (lane_ready[k+1]),
         .out_lane  (lane[k+1])
      );
   end

   // Decision and result register.
   shpg_gate_stage u_gate (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (lane_valid[shpg_pkg::NUM_CELLS]),
      .in_ready     (lane_ready[shpg_pkg::NUM_CELLS]),
      .in_lane      (lane[shpg_pkg::NUM_CELLS]),
      .out_valid    (rsp_item.valid),
      .out_ready    (rsp_item.ready),
      .out_fraction (rsp_item.random_fraction),
      .out_plays    (rsp_item.plays)
   );

   // No result is offered right after reset.
   `SHPG_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_item.valid)
   // Reset returns the seed to zero.
   `SHPG_ASSERT_NEXT_ALWAYS(a_reset_seed, clock, reset, seed_ff == 32'd0)
   // A completed seed write lands in the register.
   `SHPG_ASSERT_NEXT(a_seed_write, clock, reset, csr_write, seed_ff == $past(csr_pwdata))

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the seeded hash probability gate: hash draws, gate decision
// and seed register. Needs shpg_pkg, shpg_req_if, shpg_rsp_if and the top-level RTL.
`timescale 1ns / 100ps

module tb;
   import shpg_pkg::*;

   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 4;
   localparam int IDLE_PERCENT  = 34;
   localparam int QUIET_LIMIT   = 3000;
   localparam int SETTLE_CYCLES = 30;
   localparam int HOLD_CYCLES   = 400;
   localparam int PRINT_CAP     = 40;

   // One expected result: the random fraction and the play decision.
   typedef struct packed {
      logic [23:0] fraction;
      logic        plays;
   } draw_result_type;

   logic clock;
   logic reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   shpg_req_if req_bus ();
   shpg_rsp_if rsp_bus ();

   seeded_hash_probability_gate_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_item    (req_bus),
      .rsp_item    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Predictor state and bookkeeping.
   logic [31:0]     seed_copy;
   draw_result_type pending_draws[$];
   int error_count;
   int items_sent;
   int draws_checked;
   int seeds_written;
   int input_stall_cycles;
   int quiet_cycles;
   int hold_off_request;
   bit req_idle_on;
   bit rsp_idle_on;

   // Clock.
   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   // One hash-combine step followed by the xorshift-multiply finalizer.
   function automatic logic [31:0] absorb_word(input logic [31:0] h, input logic [31:0] v);
      logic [31:0] x;
      x = h ^ (v + COMBINE_ADD + (h << 6) + (h >> 2));
      x = x ^ (x >> 16);
      x = x * FINAL_MUL_A;
      x = x ^ (x >> 15);
      x = x * FINAL_MUL_B;
      x = x ^ (x >> 16);
      return x;
   endfunction

   // Expected fraction and play decision for one item under the given seed.
   function automatic draw_result_type predict_draw(input item_type it,
                                                    input logic [31:0] seed);
      draw_result_type r;
      logic [31:0]  h;
      logic [31:0]  scaled_fraction;
      logic [31:0]  scaled_percent;
      h = HASH_START;
      h = absorb_word(h, seed);
      h = absorb_word(h, {28'd0, it.channel});
      h = absorb_word(h, {16'd0, it.line_number});
      h = absorb_word(h, {16'd0, it.step_number});
      h = absorb_word(h, {24'd0, it.role_code});
      h = absorb_word(h, {16'd0, it.event_number});
      h = absorb_word(h, {16'd0, it.draw_number});
      r.fraction = h[31:8];
      // Both sides of the comparison fit in 31 bits.
      scaled_fraction = {8'd0, r.fraction} * 32'd100;
      scaled_percent  = {25'd0, it.play_percent} << FRACTION_BITS;
      if (!it.step_valid)
         r.plays = 1'b1;
      else if (it.is_rest)
         r.plays = 1'b0;
      else if (it.play_percent >= PERCENT_FULL)
         r.plays = 1'b1;
      else if (it.play_percent == 7'd0)
         r.plays = 1'b0;
      else
         r.plays = (scaled_fraction < scaled_percent);
      return r;
   endfunction

   function automatic item_type make_item(input logic [3:0] ch, input logic [15:0] line_no,
                                          input logic [15:0] step_no, input logic [7:0] role,
                                          input logic [15:0] event_no, input logic [15:0] draw_no,
                                          input logic valid_step, input logic rest,
                                          input logic [6:0] percent);
      item_type it;
      it.channel      = ch;
      it.line_number  = line_no;
      it.step_number  = step_no;
      it.role_code    = role;
      it.event_number = event_no;
      it.draw_number  = draw_no;
      it.step_valid   = valid_step;
      it.is_rest      = rest;
      it.play_percent = percent;
      return it;
   endfunction

   // Random item: mostly ordinary probabilities, with zero, full and rest steps mixed in.
   function automatic item_type random_item();
      item_type it;
      int pick;
      it.channel      = 4'($urandom);
      it.line_number  = 16'($urandom);
      it.step_number  = 16'($urandom);
      it.role_code    = 8'($urandom);
      it.event_number = 16'($urandom);
      it.draw_number  = 16'($urandom);
      it.step_valid   = ($urandom_range(99) < 90);
      it.is_rest      = ($urandom_range(99) < 15);
      pick = $urandom_range(99);
      if (pick < 8)
         it.play_percent = 7'd0;
      else if (pick < 20)
         it.play_percent = 7'($urandom_range(127, 100));
      else
         it.play_percent = 7'($urandom_range(99, 1));
      return it;
   endfunction

   task automatic report_mismatch(input string what);
      if (error_count < PRINT_CAP)
         $display("[%0t] mismatch: %s", $realtime, what);
      error_count++;
   endtask

   // Offer one item, with random gaps first, and return at the edge that accepts it.
   task automatic send_item(input item_type it);
      while (req_idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.channel      <= it.channel;
      req_bus.line_number  <= it.line_number;
      req_bus.step_number  <= it.step_number;
      req_bus.role_code    <= it.role_code;
      req_bus.event_number <= it.event_number;
      req_bus.draw_number  <= it.draw_number;
      req_bus.step_valid   <= it.step_valid;
      req_bus.is_rest      <= it.is_rest;
      req_bus.play_percent <= it.play_percent;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      items_sent++;
   endtask

   // Stop offering and wait until every expected result has come back.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_draws.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write: setup cycle, access cycle, then the port goes idle.
   task automatic write_seed(input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_SEED_ADDR;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      seed_copy = value;
      seeds_written++;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Register read, checked against the predictor's copy.
   task automatic check_seed_readback();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CSR_SEED_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      if (csr_prdata !== seed_copy)
         report_mismatch($sformatf("seed readback %h, expected %h", csr_prdata, seed_copy));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Predict a result for every item the block accepts.
   always @(posedge clock) begin
      item_type seen;
      if (!reset && req_bus.valid && req_bus.ready) begin
         seen.channel      = req_bus.channel;
         seen.line_number  = req_bus.line_number;
         seen.step_number  = req_bus.step_number;
         seen.role_code    = req_bus.role_code;
         seen.event_number = req_bus.event_number;
         seen.draw_number  = req_bus.draw_number;
         seen.step_valid   = req_bus.step_valid;
         seen.is_rest      = req_bus.is_rest;
         seen.play_percent = req_bus.play_percent;
         pending_draws.insert(pending_draws.size(), predict_draw(seen, seed_copy));
      end
      if (!reset && req_bus.valid && !req_bus.ready)
         input_stall_cycles++;
   end

   // Compare every accepted result with the oldest expectation.
   always @(posedge clock) begin
      draw_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_draws.size() == 0) begin
            report_mismatch($sformatf("result %h/%b with nothing expected",
                                      rsp_bus.random_fraction, rsp_bus.plays));
         end else begin
            want = pending_draws.pop_front();
            draws_checked++;
            if (rsp_bus.random_fraction !== want.fraction)
               report_mismatch($sformatf("random_fraction %h, expected %h",
                                         rsp_bus.random_fraction, want.fraction));
            if (rsp_bus.plays !== want.plays)
               report_mismatch($sformatf("plays %b, expected %b (fraction %h)",
                                         rsp_bus.plays, want.plays, want.fraction));
         end
      end
   end

   // Result-side ready: random stalls, or a long hold-off counted down here.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request > 0) begin
            stall_left = hold_off_request;
            hold_off_request = 0;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (rsp_idle_on) begin
            rsp_bus.ready <= ($urandom_range(99) >= IDLE_PERCENT);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_psel && csr_penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog expired with %0d results outstanding", pending_draws.size());
         $display("FAIL");
         $finish;
      end
   end

   // Seed register after reset, then draws under the reset seed.
   task automatic run_reset_state_test();
      check_seed_readback();
      send_item(make_item(4'd0, 16'd0, 16'd0, 8'd0, 16'd0, 16'd0, 1'b1, 1'b0, 7'd50));
      send_item(make_item(4'd15, 16'hffff, 16'hffff, 8'hff, 16'hffff, 16'hffff,
                          1'b1, 1'b0, 7'd50));
      drain_results();
   endtask

   // Field extremes and every branch of the play decision.
   task automatic run_directed_field_test();
      write_seed(32'h3f80_0000);
      check_seed_readback();
      // No valid step plays whatever rest and percent say.
      send_item(make_item(4'd1, 16'd2, 16'd3, 8'd4, 16'd5, 16'd6, 1'b0, 1'b1, 7'd0));
      send_item(make_item(4'd1, 16'd2, 16'd3, 8'd4, 16'd5, 16'd7, 1'b0, 1'b0, 7'd0));
      send_item(make_item(4'd9, 16'h8000, 16'h0001, 8'h80, 16'h7fff, 16'h8000,
                          1'b0, 1'b1, 7'd127));
      // A rest never plays, even at full percent.
      send_item(make_item(4'd2, 16'd10, 16'd11, 8'd12, 16'd13, 16'd14, 1'b1, 1'b1, 7'd100));
      send_item(make_item(4'd2, 16'd10, 16'd11, 8'd12, 16'd13, 16'd15, 1'b1, 1'b1, 7'd127));
      // Percent at or above 100 always plays.
      send_item(make_item(4'd3, 16'd20, 16'd21, 8'd22, 16'd23, 16'd24, 1'b1, 1'b0, 7'd100));
      send_item(make_item(4'd3, 16'd20, 16'd21, 8'd22, 16'd23, 16'd25, 1'b1, 1'b0, 7'd127));
      send_item(make_item(4'd3, 16'd20, 16'd21, 8'd22, 16'd23, 16'd26, 1'b1, 1'b0, 7'd101));
      // Zero percent never plays.
      send_item(make_item(4'd4, 16'd30, 16'd31, 8'd32, 16'd33, 16'd34, 1'b1, 1'b0, 7'd0));
      // Compared percentages around the ends of the range.
      send_item(make_item(4'd5, 16'd40, 16'd41, 8'd42, 16'd43, 16'd44, 1'b1, 1'b0, 7'd1));
      send_item(make_item(4'd5, 16'd40, 16'd41, 8'd42, 16'd43, 16'd45, 1'b1, 1'b0, 7'd99));
      send_item(make_item(4'd5, 16'd40, 16'd41, 8'd42, 16'd43, 16'd46, 1'b1, 1'b0, 7'd64));
      send_item(make_item(4'd0, 16'd0, 16'd0, 8'd0, 16'd0, 16'd0, 1'b1, 1'b0, 7'd0));
      send_item(make_item(4'd15, 16'hffff, 16'hffff, 8'hff, 16'hffff, 16'hffff,
                          1'b1, 1'b1, 7'd127));
      send_item(make_item(4'd15, 16'hffff, 16'hffff, 8'hff, 16'hffff, 16'hffff,
                          1'b0, 1'b0, 7'd99));
      drain_results();
   endtask

   // Seed extremes: all ones and the sign bit alone.
   task automatic run_seed_extreme_test();
      write_seed(32'hffff_ffff);
      check_seed_readback();
      send_item(make_item(4'd0, 16'd0, 16'd0, 8'd0, 16'd0, 16'd0, 1'b1, 1'b0, 7'd50));
      send_item(make_item(4'd15, 16'hffff, 16'hffff, 8'hff, 16'hffff, 16'hffff,
                          1'b1, 1'b0, 7'd50));
      send_item(make_item(4'd7, 16'd1, 16'd2, 8'd3, 16'd4, 16'd5, 1'b1, 1'b0, 7'd33));
      drain_results();
      write_seed(32'h8000_0000);
      check_seed_readback();
      send_item(make_item(4'd0, 16'd0, 16'd0, 8'd0, 16'd0, 16'd0, 1'b1, 1'b0, 7'd50));
      send_item(make_item(4'd7, 16'd1, 16'd2, 8'd3, 16'd4, 16'd5, 1'b1, 1'b0, 7'd33));
      drain_results();
   endtask

   // Random draws in phases, a new seed before each; one phase runs with no stalls.
   task automatic run_random_draw_test();
      logic [31:0] phase_seeds[6];
      phase_seeds[0] = 32'h0000_0001;
      phase_seeds[1] = $urandom;
      phase_seeds[2] = 32'h0000_0000;
      phase_seeds[3] = $urandom;
      phase_seeds[4] = 32'h7fff_ffff;
      phase_seeds[5] = $urandom;
      for (int phase = 0; phase < 6; phase++) begin
         write_seed(phase_seeds[phase]);
         req_idle_on = (phase != 3);
         rsp_idle_on = (phase != 3);
         for (int n = 0; n < 110; n++)
            send_item(random_item());
         drain_results();
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   // Long receiver hold-off while the sender keeps offering, so the pipe fills.
   task automatic run_backpressure_test();
      write_seed($urandom);
      check_seed_readback();
      req_idle_on = 1'b0;
      hold_off_request = HOLD_CYCLES;
      for (int n = 0; n < 60; n++)
         send_item(random_item());
      drain_results();
      req_idle_on = 1'b1;
   endtask

   // Reset, then the tests in turn, then the verdict.
   initial begin
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = CSR_SEED_ADDR;
      csr_pwdata = 32'd0;
      req_bus.valid = 1'b0;
      req_bus.channel = 4'd0;
      req_bus.line_number = 16'd0;
      req_bus.step_number = 16'd0;
      req_bus.role_code = 8'd0;
      req_bus.event_number = 16'd0;
      req_bus.draw_number = 16'd0;
      req_bus.step_valid = 1'b0;
      req_bus.is_rest = 1'b0;
      req_bus.play_percent = 7'd0;
      seed_copy = 32'd0;
      error_count = 0;
      items_sent = 0;
      draws_checked = 0;
      seeds_written = 0;
      input_stall_cycles = 0;
      quiet_cycles = 0;
      hold_off_request = 0;
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_reset_state_test();
      run_directed_field_test();
      run_seed_extreme_test();
      run_random_draw_test();
      run_backpressure_test();

      if (pending_draws.size() != 0)
         report_mismatch($sformatf("%0d expected results never arrived",
                                   pending_draws.size()));
      $display("Sent %0d items under %0d seed writes; %0d results compared.",
               items_sent, seeds_written, draws_checked);
      $display("Input was held back for %0d cycles; %0d mismatches seen.",
               input_stall_cycles, error_count);
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
